// ----- rtl/core/lce_pkg.sv -----
// Shared types, constants and datasheet curve points for the IGBT loss-curve evaluator.
// Used by the top module and lce_interp under rtl/core; depends on nothing.
`timescale 1ns / 1ps
package lce_pkg;

  localparam int VcePoints    = 4;
  localparam int SwitchPoints = 3;

  // Temperature span 25..125 C in 1/16 C units
  localparam logic [10:0] TempSpan = 11'd1600;
  localparam logic [12:0] TempLo   = 13'd400;
  localparam logic [12:0] TempHi   = 13'd2000;

  // Divider bank: quotient bits and latency
  localparam int DivQw    = 26;
  localparam int DivLat   = DivQw + 1;
  // Recovery energy: round and shift, partial products, partial sums, final sum
  localparam int RecQw    = 16;
  localparam int RecLat   = 4;
  localparam int InterpLat = 3;
  localparam int PipeLat  = InterpLat + 2 + DivLat + 3 + RecLat + 1;

  // Register indexes of the configuration port
  typedef enum logic [1:0] {
    RegRefVolt   = 2'd0,
    RegDiodeCold = 2'd1,
    RegDiodeHot  = 2'd2
  } reg_idx_e;

  // Datasheet points: current (1/16 A), value at 25 C, value at 125 C
  localparam logic [15:0] VceSheet [4][3] = '{
    '{16'd800,  16'd1290, 16'd1110},
    '{16'd1600, 16'd1370, 16'd1240},
    '{16'd3200, 16'd1500, 16'd1410},
    '{16'd4800, 16'd1600, 16'd1540}
  };

  // eon, eoff, irr, trr
  localparam logic [15:0] SwSheet [4][3][3] = '{
    '{'{16'd1600, 16'd3720, 16'd4640}, '{16'd3200, 16'd6370, 16'd7220},
      '{16'd4800, 16'd7800, 16'd8800}},
    '{'{16'd1600, 16'd1040, 16'd2370}, '{16'd3200, 16'd3910, 16'd6130},
      '{16'd4800, 16'd8330, 16'd11440}},
    '{'{16'd1600, 16'd316, 16'd856}, '{16'd3200, 16'd725, 16'd1094},
      '{16'd4800, 16'd825, 16'd1285}},
    '{'{16'd1600, 16'd120, 16'd245}, '{16'd3200, 16'd115, 16'd195},
      '{16'd4800, 16'd115, 16'd195}}
  };

  // Curve 0 is vce, curves 1..4 are eon, eoff, irr, trr. Points past the sheet repeat the last.
  function automatic logic [15:0] curve_point(input int curve, input int pt, input int fld);
    int src;
    logic [15:0] v;
    if (curve == 0) begin
      src = (pt < 4) ? pt : 3;
      v   = VceSheet[src][fld];
    end else begin
      src = (pt < 3) ? pt : 2;
      v   = SwSheet[curve-1][src][fld];
    end
    return v;
  endfunction

endpackage

// ----- rtl/core/igbt_loss_curve_evaluator_top.sv -----
// One beat per cycle while no result waits on a stalled output; the datapath is fully
// pipelined: five curve interpolators (3 stages), a bank of 27-stage bit-per-stage dividers
// and a 4-stage reciprocal multiply for recovery energy.
// A stall on the output freezes the whole pipeline. Reset (rst_ni low, async) empties it
// and loads reference 4800 (1/16 V) and diode drops of 2200 mV.
// Depends on lce_pkg, lce_interp, lce_div.
`timescale 1ns / 1ps
module igbt_loss_curve_evaluator_top #(
  parameter int VCE_POINTS    = lce_pkg::VcePoints,
  parameter int SWITCH_POINTS = lce_pkg::SwitchPoints
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // phase_current[14:0], bus_voltage[28:15], junction_temp[41:29], zero pad
  input  logic [47:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // vce_sat_mv[11:0], diode_vf_mv[23:12], turn_on_energy[39:24],
  // turn_off_energy[55:40], recovery_energy[71:56]
  output logic [71:0] m_axis_tdata_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [13:0] cfg_data_i
);
  import lce_pkg::*;

  localparam int DivOutIdx = InterpLat + 2 + DivLat - 1;
  localparam int RecInIdx  = DivOutIdx + 3;

  // ceil(2^22 / 25): exact floor division by 25 below 2^17
  localparam logic [17:0] VfRecip  = 18'd167773;
  localparam logic [49:0] RecHalf  = 50'd16000000000;
  // ceil(2^57 / 5^9): exact floor division by 5^9 below 2^36
  localparam logic [36:0] RecRecip = 37'd73786976295;

  function automatic logic [15:0] sat16(input logic ovf, input logic [DivQw-1:0] q);
    return (ovf || (|q[DivQw-1:16])) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic logic [11:0] sat12(input logic ovf, input logic [DivQw-1:0] q);
    return (ovf || (|q[DivQw-1:12])) ? 12'hFFF : q[11:0];
  endfunction

  logic        en;
  logic [13:0] ref_q;
  logic [11:0] cold_q, hot_q;
  logic        vld_q [PipeLat];

  logic signed [14:0] cur;
  logic signed [12:0] tj;
  logic [14:0] x_in;
  logic [10:0] a_in;
  logic [13:0] vdc_in;
  logic [22:0] dv_in;

  logic [42:0] s_w   [5];
  logic [26:0] den_w [5];

  logic [13:0] vdc_a_q [InterpLat];
  logic [22:0] dv_a_q  [InterpLat];

  // stage B
  logic [42:0] vce_n_b;
  logic [26:0] vce_dn_b, irr_dn_b, trr_dn_b;
  logic [34:0] eh_b [2];
  logic [35:0] el_b [2];
  logic [42:0] es_b [2];
  logic [26:0] ed0_b [2];
  logic [40:0] edr_b [2];
  logic [49:0] irr_n_b;
  logic [52:0] trr_n_b;
  logic [16:0] vf_m_b;
  logic [13:0] vdc_b;

  // stage C
  logic [42:0] vce_n_c;
  logic [26:0] vce_dn_c, irr_dn_c, trr_dn_c;
  logic [56:0] en_n_c [2];
  logic [40:0] en_d_c [2];
  logic [49:0] irr_n_c;
  logic [52:0] trr_n_c;
  logic [34:0] vf_prod;
  logic [11:0] vf_c;
  logic [13:0] vdc_c;

  logic [DivQw-1:0] vce_quo, irr_quo, trr_quo;
  logic [DivQw-1:0] en_quo [2];
  logic             vce_ovf, irr_ovf, trr_ovf;
  logic             en_ovf [2];
  logic [13:0]      vdc_l_q [DivLat];
  logic [11:0]      vf_l_q  [DivLat];

  // post-divider stages
  logic [55:0] res_d_q, res_e_q, res_f_q;
  logic [48:0] p_d_q;
  logic [13:0] vdc_d_q;
  logic [38:0] ph_e_q;
  logic [37:0] pl_e_q;
  logic [62:0] prod_f_q;
  logic [55:0] res_l_q [RecLat];
  logic [35:0] rec_m_q;
  logic [35:0] pp_hh_q, pp_lh_q;
  logic [36:0] pp_hl_q, pp_ll_q;
  logic [54:0] rec_x_q;
  logic [55:0] rec_y_q;
  logic [72:0] rec_sum;
  logic [RecQw-1:0] rec_q;
  logic [71:0] out_q;

  // whole pipeline advances unless a result waits on a stalled sink
  assign en              = !vld_q[PipeLat-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q  <= 14'd4800;
      cold_q <= 12'd2200;
      hot_q  <= 12'd2200;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        RegRefVolt:   ref_q  <= cfg_data_i;
        RegDiodeCold: cold_q <= cfg_data_i[11:0];
        RegDiodeHot:  hot_q  <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PipeLat; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= s_axis_tvalid_i;
      for (int i = 1; i < PipeLat; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // input unpack, |I| and temperature clamp
  assign cur    = s_axis_tdata_i[14:0];
  assign vdc_in = s_axis_tdata_i[28:15];
  assign tj     = s_axis_tdata_i[41:29];
  assign x_in   = cur[14] ? (~cur + 15'd1) : cur;

  always_comb begin
    if (tj < $signed(TempLo)) begin
      a_in = '0;
    end else if (tj > $signed(TempHi)) begin
      a_in = TempSpan;
    end else begin
      a_in = 11'(tj - $signed(TempLo));
    end
  end

  // cold*(1600-a) + hot*a, never negative
  assign dv_in = 23'(cold_q) * 23'(TempSpan - a_in) + 23'(hot_q) * 23'(a_in);

  lce_interp #(.CURVE(0), .NPTS(VCE_POINTS)) u_interp_vce (
    .clk_i(clk_i), .en_i(en), .x_i(x_in), .a_i(a_in), .s_o(s_w[0]), .den_o(den_w[0])
  );

  for (genvar c = 1; c < 5; c++) begin : g_sw
    lce_interp #(.CURVE(c), .NPTS(SWITCH_POINTS)) u_interp (
      .clk_i(clk_i), .en_i(en), .x_i(x_in), .a_i(a_in), .s_o(s_w[c]), .den_o(den_w[c])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vdc_a_q[0] <= vdc_in;
      dv_a_q[0]  <= dv_in;
      for (int i = 1; i < InterpLat; i++) begin
        vdc_a_q[i] <= vdc_a_q[i-1];
        dv_a_q[i]  <= dv_a_q[i-1];
      end
    end
  end

  // stage B: voltage scaling products, irr to mA, trr to ps
  always_ff @(posedge clk_i) begin
    if (en) begin
      vce_n_b  <= s_w[0];
      vce_dn_b <= den_w[0];
      for (int k = 0; k < 2; k++) begin
        eh_b[k]  <= 35'(s_w[k+1][42:22]) * 35'(vdc_a_q[InterpLat-1]);
        el_b[k]  <= 36'(s_w[k+1][21:0]) * 36'(vdc_a_q[InterpLat-1]);
        es_b[k]  <= s_w[k+1];
        ed0_b[k] <= den_w[k+1];
        edr_b[k] <= 41'(den_w[k+1]) * 41'(ref_q);
      end
      irr_n_b  <= 50'(s_w[3]) * 50'(100);
      irr_dn_b <= den_w[3];
      trr_n_b  <= 53'(s_w[4]) * 53'(1000);
      trr_dn_b <= den_w[4];
      // round half up, then 1600 = 64 * 25
      vf_m_b   <= 17'((dv_a_q[InterpLat-1] + 23'd800) >> 6);
      vdc_b    <= vdc_a_q[InterpLat-1];
    end
  end

  assign vf_prod = 35'(vf_m_b) * 35'(VfRecip);

  // stage C: finish the energy numerators, pick unscaled path for a zero reference
  always_ff @(posedge clk_i) begin
    if (en) begin
      vce_n_c  <= vce_n_b;
      vce_dn_c <= vce_dn_b;
      for (int k = 0; k < 2; k++) begin
        if (ref_q != '0) begin
          en_n_c[k] <= (57'(eh_b[k]) << 22) + 57'(el_b[k]);
          en_d_c[k] <= edr_b[k];
        end else begin
          en_n_c[k] <= 57'(es_b[k]);
          en_d_c[k] <= 41'(ed0_b[k]);
        end
      end
      irr_n_c  <= irr_n_b;
      irr_dn_c <= irr_dn_b;
      trr_n_c  <= trr_n_b;
      trr_dn_c <= trr_dn_b;
      vf_c     <= vf_prod[33:22];
      vdc_c    <= vdc_b;
    end
  end

  lce_div #(.NW(43), .DW(27), .QW(DivQw)) u_div_vce (
    .clk_i(clk_i), .en_i(en), .num_i(vce_n_c), .den_i(vce_dn_c),
    .quo_o(vce_quo), .ovf_o(vce_ovf)
  );

  for (genvar k = 0; k < 2; k++) begin : g_en
    lce_div #(.NW(57), .DW(41), .QW(DivQw)) u_div_en (
      .clk_i(clk_i), .en_i(en), .num_i(en_n_c[k]), .den_i(en_d_c[k]),
      .quo_o(en_quo[k]), .ovf_o(en_ovf[k])
    );
  end

  lce_div #(.NW(50), .DW(27), .QW(DivQw)) u_div_irr (
    .clk_i(clk_i), .en_i(en), .num_i(irr_n_c), .den_i(irr_dn_c),
    .quo_o(irr_quo), .ovf_o(irr_ovf)
  );

  lce_div #(.NW(53), .DW(27), .QW(DivQw)) u_div_trr (
    .clk_i(clk_i), .en_i(en), .num_i(trr_n_c), .den_i(trr_dn_c),
    .quo_o(trr_quo), .ovf_o(trr_ovf)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      vdc_l_q[0] <= vdc_c;
      vf_l_q[0]  <= vf_c;
      for (int i = 1; i < DivLat; i++) begin
        vdc_l_q[i] <= vdc_l_q[i-1];
        vf_l_q[i]  <= vf_l_q[i-1];
      end
    end
  end

  // stages D..F: irr_mA * trr_ps * vdc, saturate the other figures
  always_ff @(posedge clk_i) begin
    if (en) begin
      res_d_q  <= {sat16(en_ovf[1], en_quo[1]), sat16(en_ovf[0], en_quo[0]),
                   vf_l_q[DivLat-1], sat12(vce_ovf, vce_quo)};
      p_d_q    <= 49'(irr_quo[22:0]) * 49'(trr_quo[25:0]);
      vdc_d_q  <= vdc_l_q[DivLat-1];
      ph_e_q   <= 39'(p_d_q[48:24]) * 39'(vdc_d_q);
      pl_e_q   <= 38'(p_d_q[23:0]) * 38'(vdc_d_q);
      res_e_q  <= res_d_q;
      prod_f_q <= (63'(ph_e_q) << 24) + 63'(pl_e_q);
      res_f_q  <= res_e_q;
    end
  end

  // stages G..J: 32e9 = 2^14 * 5^9; round, drop 2^14, multiply by the reciprocal of 5^9
  assign rec_sum = (73'(rec_x_q) << 19) + 73'(rec_y_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      rec_m_q <= 36'((50'(prod_f_q[48:0]) + RecHalf) >> 14);
      pp_hh_q <= 36'(rec_m_q[35:18]) * 36'(RecRecip[36:19]);
      pp_lh_q <= 36'(rec_m_q[17:0]) * 36'(RecRecip[36:19]);
      pp_hl_q <= 37'(rec_m_q[35:18]) * 37'(RecRecip[18:0]);
      pp_ll_q <= 37'(rec_m_q[17:0]) * 37'(RecRecip[18:0]);
      rec_x_q <= (55'(pp_hh_q) << 18) + 55'(pp_lh_q);
      rec_y_q <= (56'(pp_hl_q) << 18) + 56'(pp_ll_q);
      rec_q   <= rec_sum[72:57];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_l_q[0] <= res_f_q;
      for (int i = 1; i < RecLat; i++) res_l_q[i] <= res_l_q[i-1];
      out_q <= {rec_q, res_l_q[RecLat-1]};
    end
  end

  assign m_axis_tvalid_o = vld_q[PipeLat-1];
  assign m_axis_tdata_o  = out_q;

  // current and time quotients are bounded by the 16-bit curve values
  a_irr_trr_fit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[DivOutIdx] |-> (!irr_ovf && !trr_ovf && (irr_quo[DivQw-1:23] == '0)))
    else $error("irr/trr quotient out of range");

  a_rec_fit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[RecInIdx] |-> (prod_f_q[62:49] == '0))
    else $error("recovery product out of range");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("result beat changed while stalled");

  a_out_adv : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(en))
    else $error("result appeared while pipeline was frozen");

endmodule

// ----- rtl/core/lce_div.sv -----
// Pipelined restoring divider with round-half-up, one quotient bit per stage.
// Flags a quotient that does not fit in QW bits. Uses no package items.
`timescale 1ns / 1ps
module lce_div #(
  parameter int NW = 43,
  parameter int DW = 27,
  parameter int QW = 26
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o,
  output logic          ovf_o
);

  localparam int W = ((NW + 1 > DW + QW) ? NW + 1 : DW + QW) + 1;

  logic [W-1:0]  rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW+1];
  logic          ovf_q [QW+1];
  logic [W-1:0]  n0;

  // add half the divisor for rounding, check range up front
  assign n0 = W'(num_i) + W'(den_i >> 1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= n0;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= (n0 >= (W'(den_i) << QW));
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [W-1:0] sub;
    logic         take;
    assign sub  = W'(den_q[k-1]) << (QW - k);
    assign take = rem_q[k-1] >= sub;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k] <= quo_q[k-1] | (take ? (QW'(1) << (QW - k)) : '0);
        ovf_q[k] <= ovf_q[k-1];
      end
    end

    if (k < QW) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= take ? (rem_q[k-1] - sub) : rem_q[k-1];
          den_q[k] <= den_q[k-1];
        end
      end
    end
  end

  assign quo_o = quo_q[QW];
  assign ovf_o = ovf_q[QW];

endmodule

// ----- rtl/core/lce_interp.sv -----
// One curve: segment select on |I|, current interpolation, temperature blend (3 stages).
// Gives the unscaled numerator and the denominator d*1600; depends on lce_pkg.
`timescale 1ns / 1ps
module lce_interp #(
  parameter int CURVE = 0,
  parameter int NPTS  = 4
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [14:0] x_i,
  input  logic [10:0] a_i,
  output logic [42:0] s_o,
  output logic [26:0] den_o
);
  import lce_pkg::*;

  localparam int IdxW = $clog2(NPTS);

  logic [15:0] v0a, v1a, v0b, v1b, d_c, f_c;
  logic [15:0] v0a_q, v1a_q, v0b_q, v1b_q, d1_q, f1_q, d2_q;
  logic [10:0] a1_q, a2_q;
  logic [31:0] w25_q, w125_q;
  logic [42:0] s_q;
  logic [26:0] den_q;

  always_comb begin
    logic [IdxW-1:0] lo, hi;
    logic [15:0]     x16;
    x16 = {1'b0, x_i};
    lo  = '0;
    hi  = '0;
    d_c = 16'd1;
    f_c = '0;
    if (x16 <= curve_point(CURVE, 0, 0)) begin
      lo = '0;
      hi = '0;
    end else if (x16 >= curve_point(CURVE, NPTS - 1, 0)) begin
      lo = IdxW'(NPTS - 1);
      hi = IdxW'(NPTS - 1);
    end else begin
      lo = IdxW'(NPTS - 1);
      hi = IdxW'(NPTS - 1);
      // walk down so the first segment that covers x wins
      for (int i = NPTS - 1; i >= 1; i--) begin
        if (x16 <= curve_point(CURVE, i, 0)) begin
          lo = IdxW'(i - 1);
          if (curve_point(CURVE, i, 0) <= curve_point(CURVE, i - 1, 0)) begin
            hi  = IdxW'(i - 1);
            d_c = 16'd1;
            f_c = '0;
          end else begin
            hi  = IdxW'(i);
            d_c = curve_point(CURVE, i, 0) - curve_point(CURVE, i - 1, 0);
            f_c = x16 - curve_point(CURVE, i - 1, 0);
          end
        end
      end
    end
    v0a = '0;
    v1a = '0;
    v0b = '0;
    v1b = '0;
    for (int i = 0; i < NPTS; i++) begin
      if (lo == IdxW'(i)) begin
        v0a = curve_point(CURVE, i, 1);
        v0b = curve_point(CURVE, i, 2);
      end
      if (hi == IdxW'(i)) begin
        v1a = curve_point(CURVE, i, 1);
        v1b = curve_point(CURVE, i, 2);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v0a_q  <= v0a;
      v1a_q  <= v1a;
      v0b_q  <= v0b;
      v1b_q  <= v1b;
      d1_q   <= d_c;
      f1_q   <= f_c;
      a1_q   <= a_i;
      // v0*(d-f) + v1*f stays below 2^32
      w25_q  <= 32'(v0a_q) * 32'(d1_q - f1_q) + 32'(v1a_q) * 32'(f1_q);
      w125_q <= 32'(v0b_q) * 32'(d1_q - f1_q) + 32'(v1b_q) * 32'(f1_q);
      d2_q   <= d1_q;
      a2_q   <= a1_q;
      s_q    <= 43'(w25_q) * 43'(TempSpan - a2_q) + 43'(w125_q) * 43'(a2_q);
      den_q  <= 27'(d2_q) * 27'(TempSpan);
    end
  end

  assign s_o   = s_q;
  assign den_o = den_q;

endmodule

// ----- test/igbt_loss_curve_evaluator_top_test.sv -----
// Stream testbench for igbt_loss_curve_evaluator_top: random and corner samples, bursty
// input, stalling output, register phases; results checked against an in-bench predictor.
// Depends on lce_pkg and the igbt_loss_curve_evaluator_top RTL.
`timescale 1ns / 1ps
module igbt_loss_curve_evaluator_top_test;
  import lce_pkg::*;

  localparam logic [1:0] RegUnused = 2'd3;  // index past the register list, ignored
  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 80;

  typedef struct packed {
    logic [15:0] rec;
    logic [15:0] eoff;
    logic [15:0] eon;
    logic [11:0] vf;
    logic [11:0] vce;
  } loss_t;

  class loss_scoreboard;
    longint rom[3*VcePoints + 12*SwitchPoints];
    longint ref_volt, drop_cold, drop_hot;
    loss_t expected_q[$];
    int errors;

    function new();
      for (int i = 0; i < VcePoints; i++)
        for (int j = 0; j < 3; j++) rom[3*i+j] = VceSheet[i][j];
      for (int k = 0; k < 4; k++)
        for (int i = 0; i < SwitchPoints; i++)
          for (int j = 0; j < 3; j++)
            rom[3*VcePoints + 3*SwitchPoints*k + 3*i + j] = SwSheet[k][i][j];
      ref_volt = 4800;
      drop_cold = 2200;
      drop_hot = 2200;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [13:0] val);
      case (idx)
        RegRefVolt:   ref_volt = val;
        RegDiodeCold: drop_cold = val[11:0];
        RegDiodeHot:  drop_hot = val[11:0];
        default: ;
      endcase
    endfunction

    function longint rdiv(longint num, longint den);
      if (den == 0) return 0;
      return (num + den / 2) / den;
    endfunction

    function longint clip(longint v, longint hi);
      return (v > hi) ? hi : v;
    endfunction

    // Interpolate one curve in current, blend in temperature; returns num, den
    function void interp(int base, int n, longint x, longint a,
                         output longint num, output longint den);
      int last, lo, hi;
      longint d, f, v25, v125, s;
      last = base + 3 * (n - 1);
      lo = base;
      hi = base;
      d = 1;
      f = 0;
      if (x <= rom[base]) begin
        lo = base;
      end else if (x >= rom[last]) begin
        lo = last;
        hi = last;
      end else begin
        lo = last;
        hi = last;
        for (int i = 1; i < n; i++) begin
          if (x <= rom[base + 3*i]) begin
            lo = base + 3*i - 3;
            hi = base + 3*i;
            d = rom[hi] - rom[lo];
            f = x - rom[lo];
            break;
          end
        end
        if (d <= 0) begin
          d = 1;
          f = 0;
          hi = lo;
        end
      end
      v25 = rom[lo+1] * d + f * (rom[hi+1] - rom[lo+1]);
      v125 = rom[lo+2] * d + f * (rom[hi+2] - rom[lo+2]);
      s = v25 * TempSpan + a * (v125 - v25);
      num = (s < 0) ? 0 : s;
      den = d * TempSpan;
    endfunction

    function void note_sample(logic [47:0] beat);
      longint x, vdc, t, a, num, den, dv, irr, trr, e;
      int sw;
      loss_t r;
      x = longint'($signed(beat[14:0]));
      if (x < 0) x = -x;
      vdc = beat[28:15];
      t = longint'($signed(beat[41:29]));
      if (t < longint'(TempLo)) t = TempLo;
      if (t > longint'(TempHi)) t = TempHi;
      a = t - TempLo;
      sw = 3 * VcePoints;
      interp(0, VcePoints, x, a, num, den);
      r.vce = 12'(clip(rdiv(num, den), 4095));
      dv = drop_cold * TempSpan + a * (drop_hot - drop_cold);
      if (dv < 0) dv = 0;
      r.vf = 12'(clip(rdiv(dv, TempSpan), 4095));
      interp(sw, SwitchPoints, x, a, num, den);
      e = (ref_volt != 0) ? rdiv(num * vdc, den * ref_volt) : rdiv(num, den);
      r.eon = 16'(clip(e, 65535));
      interp(sw + 3*SwitchPoints, SwitchPoints, x, a, num, den);
      e = (ref_volt != 0) ? rdiv(num * vdc, den * ref_volt) : rdiv(num, den);
      r.eoff = 16'(clip(e, 65535));
      interp(sw + 6*SwitchPoints, SwitchPoints, x, a, num, den);
      irr = rdiv(num * 100, den);
      interp(sw + 9*SwitchPoints, SwitchPoints, x, a, num, den);
      trr = rdiv(num * 1000, den);
      r.rec = 16'(clip(rdiv(vdc * irr * trr, 64'd32000000000), 65535));
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [71:0] beat);
      loss_t got, exp_r;
      got = beat;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, beat);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.vce !== exp_r.vce) begin
        $display("%0t: vce_sat_mv expected %0d actual %0d", $time, exp_r.vce, got.vce);
        errors++;
      end
      if (got.vf !== exp_r.vf) begin
        $display("%0t: diode_vf_mv expected %0d actual %0d", $time, exp_r.vf, got.vf);
        errors++;
      end
      if (got.eon !== exp_r.eon) begin
        $display("%0t: turn_on_energy expected %0d actual %0d", $time, exp_r.eon, got.eon);
        errors++;
      end
      if (got.eoff !== exp_r.eoff) begin
        $display("%0t: turn_off_energy expected %0d actual %0d", $time, exp_r.eoff, got.eoff);
        errors++;
      end
      if (got.rec !== exp_r.rec) begin
        $display("%0t: recovery_energy expected %0d actual %0d", $time, exp_r.rec, got.rec);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [71:0] m_axis_tdata_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [13:0] cfg_data_i = '0;

  loss_scoreboard loss_sb = new();
  int cycle_count = 0;
  int burst_left = 0;
  int ready_pct = 100;

  igbt_loss_curve_evaluator_top dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("igbt_loss_curve_evaluator_top test failed");
      $finish;
    end
  end

  // Output side: check accepted beats, stall on a slowly changing duty
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) loss_sb.check_result(m_axis_tdata_o);
    if (cycle_count % 300 == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pct = 100;
        1: ready_pct = 80;
        2: ready_pct = 40;
        default: ready_pct = 10;
      endcase
    end
    m_axis_tready_i <= ($urandom_range(1, 100) <= ready_pct);
  end

  task automatic write_reg(input logic [1:0] idx, input logic [13:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    loss_sb.write_reg(idx, val);
    cfg_valid_i <= 1'b0;
  endtask

  // Send one sample; between bursts drop valid and idle a random gap
  task automatic send_sample(input logic [14:0] cur, input logic [13:0] vdc,
                             input logic [12:0] tj);
    logic [47:0] beat;
    beat = {6'b0, tj, vdc, cur};
    if (burst_left == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= beat;
    do @(posedge clk_i); while (!s_axis_tready_o);
    loss_sb.note_sample(beat);
    burst_left--;
  endtask

  task automatic send_random(input int count);
    logic [14:0] cur;
    logic [12:0] tj;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 6) begin
        cur = 15'($urandom_range(0, 5200));
        if ($urandom_range(0, 1)) cur = -cur;
      end else begin
        cur = 15'($urandom);
      end
      if ($urandom_range(0, 9) < 7) tj = 13'($urandom_range(300, 2100));
      else tj = 13'($urandom_range(0, 5119) - 1024);
      send_sample(cur, 14'($urandom), tj);
    end
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    while (loss_sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Corners: current at and around each curve point, both end clamps, temp clamps
    send_sample(15'd0, 14'd4800, 13'd400);
    send_sample(-15'sd16384, 14'd16383, 13'd2000);
    send_sample(15'd16383, 14'd0, -13'sd1024);
    send_sample(15'd799, 14'd4800, 13'd399);
    send_sample(15'd800, 14'd4800, 13'd2001);
    send_sample(15'd801, 14'd3000, 13'd1200);
    send_sample(15'd1600, 14'd8000, 13'd4095);
    send_sample(-15'sd1601, 14'd4800, 13'd800);
    send_sample(15'd2400, 14'd12000, 13'd1600);
    send_sample(15'd3200, 14'd4800, 13'd1999);
    send_sample(-15'sd4000, 14'd1, 13'd401);
    send_sample(15'd4800, 14'd16383, 13'd400);
    send_sample(15'd4801, 14'd16383, 13'd2000);
    send_sample(-15'sd1, 14'd100, -13'sd1);
    send_sample(15'd1200, 14'd7000, 13'd0);
    drain();

    send_random(300);
    drain();

    write_reg(RegRefVolt, 14'd0);
    write_reg(RegDiodeCold, 14'd0);
    write_reg(RegDiodeHot, 14'd4095);
    send_random(250);
    drain();

    write_reg(RegRefVolt, 14'd16383);
    write_reg(RegDiodeCold, 14'd4095);
    write_reg(RegDiodeHot, 14'd0);
    write_reg(RegUnused, 14'h3FFF);
    send_random(250);
    drain();

    // Tiny reference drives the energies into saturation
    write_reg(RegRefVolt, 14'd1);
    write_reg(RegDiodeCold, 14'd1234);
    write_reg(RegDiodeHot, 14'd3000);
    send_random(200);
    drain();

    write_reg(RegRefVolt, 14'($urandom));
    write_reg(RegDiodeCold, 14'($urandom));
    write_reg(RegDiodeHot, 14'($urandom));
    send_random(300);
    drain();

    if (loss_sb.errors == 0 && loss_sb.expected_q.size() == 0) begin
      $display("igbt_loss_curve_evaluator_top test passed");
    end else begin
      $display("igbt_loss_curve_evaluator_top test failed");
    end
    $finish;
  end
endmodule
